@@ rtl/core/ktls_pkg.sv @@
// ----------------------------------------------------------------------------
// ktls_pkg
// Shared types and constants for the keyframe track sampler.
// ----------------------------------------------------------------------------
package ktls_pkg;

   localparam int TIME_W = 24;
   localparam int VAL_W  = 32;
   localparam int CNT_W  = 7;

   localparam logic ACTION_LOAD   = 1'b0;
   localparam logic ACTION_SAMPLE = 1'b1;

   localparam logic [1:0] STATUS_INTERP = 2'd0;
   localparam logic [1:0] STATUS_SINGLE = 2'd1;
   localparam logic [1:0] STATUS_HELD   = 2'd2;
   localparam logic [1:0] STATUS_ZERO   = 2'd3;

   typedef struct packed {
      logic                     action;
      logic [5:0]               key_index;
      logic [TIME_W-1:0]        key_time;
      logic signed [VAL_W-1:0]  key_x;
      logic signed [VAL_W-1:0]  key_y;
      logic signed [VAL_W-1:0]  key_z;
      logic [TIME_W-1:0]        sample_tick;
   } req_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] out_x;
      logic signed [VAL_W-1:0] out_y;
      logic signed [VAL_W-1:0] out_z;
      logic [1:0]              status;
   } rsp_type;

   typedef struct packed {
      logic [TIME_W-1:0]       t;
      logic signed [VAL_W-1:0] x;
      logic signed [VAL_W-1:0] y;
      logic signed [VAL_W-1:0] z;
   } key_type;

   localparam int KEY_W = TIME_W + 3 * VAL_W;

endpackage

@@ rtl/core/ktls_ram.sv @@
// ----------------------------------------------------------------------------
// ktls_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module ktls_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

@@ rtl/core/keyframe_track_lerp_sampler.sv @@
// ----------------------------------------------------------------------------
// keyframe_track_lerp_sampler
// Samples a track of 3-vector keyframes with linear interpolation.
// ----------------------------------------------------------------------------
// A load transfer writes one keyframe into the table at its accepting edge,
// and the next transfer can be taken in the following cycle. A sample transfer scans
// the table one key per cycle through the single read port of the key memory
// until it finds the first key whose successor time exceeds the tick. It then
// forms the fraction (p1 - p0) * (tick - t0) / (t1 - t0) for each component
// with a shared restoring divider (one setup step plus 59 shift steps) and a
// 33x26 multiplier used once per component. A single key is answered with
// key 0, a held last key is answered with that key, and a zero interval
// answers with the earlier key. One transfer is worked on at a time. The
// result sits in an output register, and the next request is taken in the
// cycle after the result has been handed over. Times are unsigned Q16.8,
// values are signed Q16.16, results saturate to the signed 32-bit range. A
// key count of zero acts as one and counts above MAX_KEYS act as MAX_KEYS.
// Keys that were never loaded read back as arbitrary data.
module keyframe_track_lerp_sampler #(
   parameter int MAX_KEYS = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  ktls_pkg::req_type   req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output ktls_pkg::rsp_type   rsp_data,
   input  logic                csr_we,
   input  logic [6:0]          csr_wdata
);
   import ktls_pkg::*;

   localparam int AW = $clog2(MAX_KEYS);
   localparam int IW = AW + 1;
   // Numerator/divisor magnitudes fit 25 bits; product 58 bits signed.
   localparam int DW = 25;
   localparam int PW = 59;

   typedef enum logic [8:0] {
      S_IDLE  = 9'b000000001,
      S_RD0   = 9'b000000010,
      S_SCAN  = 9'b000000100,
      S_PAIR  = 9'b000001000,
      S_SETUP = 9'b000010000,
      S_MUL   = 9'b000100000,
      S_DIV   = 9'b001000000,
      S_ADD   = 9'b010000000,
      S_OUT   = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   logic [CNT_W-1:0] count_ff, count_in;
   logic [IW-1:0]    n_eff;
   logic [IW-1:0]    idx_ff, idx_in;
   logic [TIME_W-1:0] tick_ff, tick_in;
   key_type           k0_ff, k0_in, k1_ff, k1_in;
   logic [1:0]        comp_ff, comp_in;
   logic signed [PW-1:0] prod_ff, prod_in;
   logic [PW-1:0]     quo_ff, quo_in;
   logic [DW:0]       rem_ff, rem_in;
   logic [DW-1:0]     dmag_ff, dmag_in;
   logic              qneg_ff, qneg_in;
   logic [5:0]        step_ff, step_in;
   logic signed [VAL_W-1:0] res_ff [3];
   logic signed [VAL_W-1:0] res_in [3];
   logic [1:0]        stat_ff, stat_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // Key memory.
   logic           wr_en;
   logic [AW-1:0]  rd_addr;
   logic [KEY_W-1:0] rd_raw;
   key_type        rd_key;
   key_type        wr_key;

   assign wr_key  = '{t: req_data.key_time, x: req_data.key_x,
                      y: req_data.key_y, z: req_data.key_z};
   assign rd_key  = key_type'(rd_raw);

   ktls_ram #(.WIDTH(KEY_W), .DEPTH(MAX_KEYS)) u_keys (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(AW'(req_data.key_index)),
      .wr_data(wr_key),
      .rd_addr(rd_addr),
      .rd_data(rd_raw)
   );

   // Effective key count.
   always_comb begin
      if (count_ff == '0) begin
         n_eff = IW'(1);
      end else if (32'(count_ff) > MAX_KEYS) begin
         n_eff = IW'(MAX_KEYS);
      end else begin
         n_eff = IW'(count_ff);
      end
   end

   logic req_take;
   assign req_stall = (state_ff != S_IDLE) || rsp_valid_ff;
   assign req_take  = req_valid && !req_stall;
   // Loads beyond the table (only possible when MAX_KEYS < 64) are dropped.
   assign wr_en = req_take && (req_data.action == ACTION_LOAD) &&
                  (32'(req_data.key_index) < MAX_KEYS);

   // Component select helpers.
   logic signed [VAL_W-1:0] p0_sel, p1_sel;
   always_comb begin
      case (comp_ff)
         2'd0:    begin p0_sel = k0_ff.x; p1_sel = k1_ff.x; end
         2'd1:    begin p0_sel = k0_ff.y; p1_sel = k1_ff.y; end
         default: begin p0_sel = k0_ff.z; p1_sel = k1_ff.z; end
      endcase
   end

   logic signed [VAL_W:0]  diff;
   logic signed [DW:0]     num_s, dt_s;
   logic signed [PW-1:0]   mul_res;
   logic [PW-1:0]          prod_mag;
   logic [DW:0]            rem_sh;
   logic signed [PW-1:0]   q_signed;
   logic signed [PW-1:0]   sum;
   logic signed [VAL_W-1:0] sat;

   assign diff    = (VAL_W+1)'(p1_sel) - (VAL_W+1)'(p0_sel);
   assign num_s   = (DW+1)'({1'b0, tick_ff}) - (DW+1)'({1'b0, k0_ff.t});
   assign dt_s    = (DW+1)'({1'b0, k1_ff.t}) - (DW+1)'({1'b0, k0_ff.t});
   assign mul_res = PW'(diff) * PW'(num_s);
   assign prod_mag = prod_ff[PW-1] ? PW'(-prod_ff) : PW'(prod_ff);
   assign rem_sh  = {rem_ff[DW-1:0], quo_ff[PW-1]};
   assign q_signed = qneg_ff ? -$signed(quo_ff) : $signed(quo_ff);
   // The quotient can reach 56 bits, so the sum keeps the full width.
   assign sum     = PW'(p0_sel) + q_signed;
   always_comb begin
      if (sum > PW'(32'sh7FFFFFFF)) begin
         sat = 32'sh7FFFFFFF;
      end else if (sum < -PW'(33'sh080000000)) begin
         sat = 32'sh80000000;
      end else begin
         sat = VAL_W'(sum);
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = csr_we ? csr_wdata : count_ff;
      idx_in       = idx_ff;
      tick_in      = tick_ff;
      k0_in        = k0_ff;
      k1_in        = k1_ff;
      comp_in      = comp_ff;
      prod_in      = prod_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      dmag_in      = dmag_ff;
      qneg_in      = qneg_ff;
      step_in      = step_ff;
      res_in       = res_ff;
      stat_in      = stat_ff;
      rsp_valid_in = rsp_valid_ff;
      rd_addr      = '0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_take && req_data.action == ACTION_SAMPLE) begin
               tick_in  = req_data.sample_tick;
               idx_in   = '0;
               state_in = S_RD0;
            end
         end
         S_RD0: begin
            // Address 0 issued now; data arrives next cycle.
            rd_addr  = '0;
            idx_in   = IW'(1);
            state_in = S_SCAN;
            if (n_eff == IW'(1)) begin
               stat_in  = STATUS_SINGLE;
               state_in = S_PAIR;
            end
         end
         default: ;
      endcase

      // Scan is implemented as a walking read below; the case above only
      // routes into it. Detailed sequencing:
      case (state_ff)
         S_SCAN: begin
            // First cycle: rd_key = key 0.
            k0_in    = rd_key;
            rd_addr  = idx_ff[AW-1:0];
            state_in = S_PAIR;
            stat_in  = STATUS_INTERP;
         end
         S_PAIR: begin
            if (n_eff == IW'(1) && idx_ff == IW'(1) && stat_ff == STATUS_SINGLE) begin
               // Key 0 is on the read port now.
               k0_in    = rd_key;
               res_in[0] = rd_key.x;
               res_in[1] = rd_key.y;
               res_in[2] = rd_key.z;
               state_in = S_OUT;
            end else begin
               // rd_key = key idx_ff, k0_ff = key idx_ff - 1.
               k1_in = rd_key;
               if (tick_ff < rd_key.t) begin
                  state_in = S_SETUP;
               end else if (idx_ff + IW'(1) >= n_eff) begin
                  res_in[0] = rd_key.x;
                  res_in[1] = rd_key.y;
                  res_in[2] = rd_key.z;
                  stat_in   = STATUS_HELD;
                  state_in  = S_OUT;
               end else begin
                  k0_in    = rd_key;
                  idx_in   = idx_ff + IW'(1);
                  rd_addr  = AW'(idx_ff + IW'(1));
                  state_in = S_PAIR;
               end
            end
         end
         S_SETUP: begin
            comp_in = 2'd0;
            if (dt_s == '0) begin
               res_in[0] = k0_ff.x;
               res_in[1] = k0_ff.y;
               res_in[2] = k0_ff.z;
               stat_in   = STATUS_ZERO;
               state_in  = S_OUT;
            end else begin
               dmag_in  = dt_s[DW] ? DW'(-dt_s) : DW'(dt_s);
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            prod_in  = mul_res;
            state_in = S_DIV;
            step_in  = '0;
            rem_in   = '0;
         end
         S_DIV: begin
            if (step_ff == '0) begin
               quo_in  = prod_mag;
               qneg_in = prod_ff[PW-1] ^ dt_s[DW];
               rem_in  = '0;
               step_in = 6'd1;
            end else begin
               if (rem_sh >= {1'b0, dmag_ff}) begin
                  rem_in = rem_sh - {1'b0, dmag_ff};
                  quo_in = {quo_ff[PW-2:0], 1'b1};
               end else begin
                  rem_in = rem_sh;
                  quo_in = {quo_ff[PW-2:0], 1'b0};
               end
               if (step_ff == 6'(PW)) begin
                  state_in = S_ADD;
               end
               step_in = step_ff + 6'd1;
            end
         end
         S_ADD: begin
            res_in[comp_ff] = sat;
            if (comp_ff == 2'd2) begin
               state_in = S_OUT;
            end else begin
               comp_in  = comp_ff + 2'd1;
               state_in = S_MUL;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= CNT_W'(1);
         rsp_valid_ff <= 1'b0;
         stat_ff      <= STATUS_INTERP;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         stat_ff      <= stat_in;
      end
      idx_ff  <= idx_in;
      tick_ff <= tick_in;
      k0_ff   <= k0_in;
      k1_ff   <= k1_in;
      comp_ff <= comp_in;
      prod_ff <= prod_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      dmag_ff <= dmag_in;
      qneg_ff <= qneg_in;
      step_ff <= step_in;
      res_ff  <= res_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data.out_x  = res_ff[0];
   assign rsp_data.out_y  = res_ff[1];
   assign rsp_data.out_z  = res_ff[2];
   assign rsp_data.status = stat_ff;

endmodule
